### design/pitt_pkg.sv
// Shared constants and types for the point-in-triangle test unit.
package pitt_pkg;

   // Default coordinate width of the vertex and query point fields
   localparam int COORD_WIDTH_DEFAULT = 24;

   // Barycentric tolerance is a fraction with this many fractional bits
   localparam int FRAC_BITS = 32;

   // Configuration register reset values
   localparam logic [31:0] BARY_TOL_RESET  = 32'd4;
   localparam logic [15:0] PLANE_TOL_RESET = 16'd0;

   // Configuration port address width (two 32-bit registers)
   localparam int CSR_ADDR_WIDTH = 3;

   // Wide multiplier: limb width of one partial product operand and
   // depth of the registered adder tree (up to 2**depth partial products)
   localparam int MUL_LIMB_WIDTH = 31;
   localparam int MUL_TREE_DEPTH = 4;

   // Register select, taken from the word address bit
   typedef enum logic {
      CSR_BARY_TOL  = 1'b0,
      CSR_PLANE_TOL = 1'b1
   } csr_reg_type;

endpackage

### design/pitt_mul.sv
// Pipelined signed multiplier for wide operands.
// Operands are cut into limbs, limb products are registered, then summed
// through a balanced registered adder tree. All registers move only on
// advance.
module pitt_mul #(
   parameter int A_WIDTH    = 8,
   parameter int B_WIDTH    = 8,
   parameter int LIMB_WIDTH = pitt_pkg::MUL_LIMB_WIDTH,
   parameter int TREE_DEPTH = pitt_pkg::MUL_TREE_DEPTH
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int NA     = (A_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int NB     = (B_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int AXW    = NA * LIMB_WIDTH;
   localparam int BXW    = NB * LIMB_WIDTH;
   localparam int PW     = A_WIDTH + B_WIDTH;
   localparam int PPW    = 2 * LIMB_WIDTH + 2;
   localparam int NPP    = NA * NB;
   localparam int LEAVES = 2 ** TREE_DEPTH;
   localparam int NODES  = LEAVES - 1;

   logic signed [AXW-1:0]        a_ext;
   logic signed [BXW-1:0]        b_ext;
   logic signed [LIMB_WIDTH:0]   a_limb [NA];
   logic signed [LIMB_WIDTH:0]   b_limb [NB];
   logic signed [PPW-1:0]        pp_ff [NPP];
   logic        [PW-1:0]         node [NODES+LEAVES];
   logic        [PW-1:0]         tree_ff [NODES];

   assign a_ext = AXW'(a);
   assign b_ext = BXW'(b);

   // Limb split: lower limbs unsigned, top limb carries the sign
   genvar gi, gj, gk;
   generate
      for (gi = 0; gi < NA; gi++) begin : g_a_limb
         if (gi == NA - 1) begin : g_top
            assign a_limb[gi] = {a_ext[AXW-1], a_ext[gi*LIMB_WIDTH +: LIMB_WIDTH]};
         end else begin : g_low
            assign a_limb[gi] = {1'b0, a_ext[gi*LIMB_WIDTH +: LIMB_WIDTH]};
         end
      end
      for (gj = 0; gj < NB; gj++) begin : g_b_limb
         if (gj == NB - 1) begin : g_top
            assign b_limb[gj] = {b_ext[BXW-1], b_ext[gj*LIMB_WIDTH +: LIMB_WIDTH]};
         end else begin : g_low
            assign b_limb[gj] = {1'b0, b_ext[gj*LIMB_WIDTH +: LIMB_WIDTH]};
         end
      end

      // Limb products, one register each
      for (gi = 0; gi < NA; gi++) begin : g_pp_row
         for (gj = 0; gj < NB; gj++) begin : g_pp_col
            localparam int K = gi * NB + gj;
            always_ff @(posedge clock) begin
               if (advance) begin
                  pp_ff[K] <= a_limb[gi] * b_limb[gj];
               end
            end
         end
      end

      // Tree leaves: products aligned to their limb weight, rest zero
      for (gk = 0; gk < LEAVES; gk++) begin : g_leaf
         if (gk < NPP) begin : g_used
            localparam int SHIFT = ((gk / NB) + (gk % NB)) * LIMB_WIDTH;
            assign node[NODES+gk] = PW'(pp_ff[gk]) << SHIFT;
         end else begin : g_zero
            assign node[NODES+gk] = '0;
         end
      end

      // Registered adder tree, heap order: node n sums 2n+1 and 2n+2
      for (gk = 0; gk < NODES; gk++) begin : g_tree
         always_ff @(posedge clock) begin
            if (advance) begin
               tree_ff[gk] <= node[2*gk+1] + node[2*gk+2];
            end
         end
         assign node[gk] = tree_ff[gk];
      end
   endgenerate

   assign p = node[0];

endmodule

### design/point_in_triangle_test_unit.sv
// Channel   Direction  Handshake                    Word
// req       in         req_valid / req_stall        vertices a, b, c and point p
// rsp       out        rsp_valid / rsp_stall        inside_res, degenerate
// config    in/out     psel penable pwrite pready   bary_tolerance @0, plane_tolerance @4
//
// One word accepted per cycle while no result is held; each word passes
// through difference, product and dot-product stages, then two wide
// multiplier trees in series (limb products plus four adder levels each),
// a combine stage between them and the output register.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; no word is dropped or repeated.
module point_in_triangle_test_unit #(
   parameter int COORD_WIDTH = pitt_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_a_y,
   input  logic signed [COORD_WIDTH-1:0]         req_a_z,
   input  logic signed [COORD_WIDTH-1:0]         req_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_b_y,
   input  logic signed [COORD_WIDTH-1:0]         req_b_z,
   input  logic signed [COORD_WIDTH-1:0]         req_c_x,
   input  logic signed [COORD_WIDTH-1:0]         req_c_y,
   input  logic signed [COORD_WIDTH-1:0]         req_c_z,
   input  logic signed [COORD_WIDTH-1:0]         req_p_x,
   input  logic signed [COORD_WIDTH-1:0]         req_p_y,
   input  logic signed [COORD_WIDTH-1:0]         req_p_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_inside_res,
   output logic                                  rsp_degenerate,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pitt_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   // Datapath widths
   localparam int DW    = COORD_WIDTH + 1;          // edge / offset vector
   localparam int PRW   = 2 * DW;                   // coordinate product
   localparam int DOTW  = 2 * DW + 2;               // dot product
   localparam int NW    = 2 * DW + 1;               // normal component
   localparam int NWW   = NW + DW + 2;              // normal dot offset
   localparam int DETW  = 2 * DOTW + 1;             // Gram determinant, U, V
   localparam int DMW   = DETW + 2;                 // D - U - V
   localparam int TOLW  = pitt_pkg::FRAC_BITS + 1;  // tolerance operand
   localparam int BTW   = DETW + TOLW;              // tolerance times D
   localparam int FW    = (2 * NWW > DETW + 35) ? 2 * NWW : DETW + 35;
   localparam int TREE  = pitt_pkg::MUL_TREE_DEPTH;
   localparam int LIMB  = pitt_pkg::MUL_LIMB_WIDTH;
   localparam int ML    = 1 + TREE;                 // multiplier latency
   localparam int LAT   = 3 + ML + 1 + ML + 1;      // word to result

   typedef struct packed {
      logic signed [DETW-1:0] un;
      logic signed [DETW-1:0] vn;
      logic signed [DMW-1:0]  dmuv;
      logic                   degen;
   } dly_type;

   // Pipeline control
   logic                       advance;
   logic [LAT-1:0]             valid_ff;

   // Configuration
   logic [31:0]                bary_ff;
   logic [15:0]                tol_ff;
   logic [31:0]                tolsq_ff;
   logic signed [TOLW-1:0]     bary_op;
   logic signed [TOLW-1:0]     tolsq_op;
   pitt_pkg::csr_reg_type      csr_sel;

   // Input coordinates as vectors
   logic signed [COORD_WIDTH-1:0] a_in [3];
   logic signed [COORD_WIDTH-1:0] b_in [3];
   logic signed [COORD_WIDTH-1:0] c_in [3];
   logic signed [COORD_WIDTH-1:0] p_in [3];

   // Stage 1: edges and offset
   logic signed [DW-1:0]       e0_ff [3];
   logic signed [DW-1:0]       e1_ff [3];
   logic signed [DW-1:0]       w1_ff [3];

   // Stage 2: coordinate products
   logic signed [PRW-1:0]      p00_ff [3];
   logic signed [PRW-1:0]      p01_ff [3];
   logic signed [PRW-1:0]      p02_ff [3];
   logic signed [PRW-1:0]      p11_ff [3];
   logic signed [PRW-1:0]      p12_ff [3];
   logic signed [PRW-1:0]      cra_ff [3];
   logic signed [PRW-1:0]      crb_ff [3];
   logic signed [DW-1:0]       w2_ff [3];

   // Stage 3: dot products and normal
   logic signed [DOTW-1:0]     d00_ff;
   logic signed [DOTW-1:0]     d01_ff;
   logic signed [DOTW-1:0]     d02_ff;
   logic signed [DOTW-1:0]     d11_ff;
   logic signed [DOTW-1:0]     d12_ff;
   logic signed [NW-1:0]       n_ff [3];
   logic signed [DW-1:0]       w3_ff [3];

   // First multiplier bank outputs
   logic signed [2*DOTW-1:0]   m_d00d11;
   logic signed [2*DOTW-1:0]   m_d01d01;
   logic signed [2*DOTW-1:0]   m_d11d02;
   logic signed [2*DOTW-1:0]   m_d01d12;
   logic signed [2*DOTW-1:0]   m_d00d12;
   logic signed [2*DOTW-1:0]   m_d01d02;
   logic signed [NW+DW-1:0]    m_nw [3];

   // Stage 4: determinant, numerators, plane offset
   logic signed [DETW-1:0]     det_ff;
   logic signed [DETW-1:0]     un_ff;
   logic signed [DETW-1:0]     vn_ff;
   logic signed [NWW-1:0]      nw_ff;

   // Second multiplier bank and its side delay line
   logic signed [BTW-1:0]      m_bt;
   logic signed [BTW-1:0]      m_td;
   logic signed [2*NWW-1:0]    m_nw2;
   dly_type                    dly_in;
   dly_type                    dly_ff [ML];
   dly_type                    dly_last;

   // Final compare
   logic signed [FW-1:0]       sum_u;
   logic signed [FW-1:0]       sum_v;
   logic signed [FW-1:0]       sum_s;
   logic signed [FW-1:0]       sum_p;
   logic                       inside_in;
   logic                       inside_ff;
   logic                       degen_ff;

   // ------------------------------------------------------------------
   // Handshake: the whole pipeline moves unless a result is held
   assign advance   = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers
   assign csr_sel = pitt_pkg::csr_reg_type'(paddr[2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bary_ff <= pitt_pkg::BARY_TOL_RESET;
         tol_ff  <= pitt_pkg::PLANE_TOL_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (csr_sel)
            pitt_pkg::CSR_BARY_TOL:  bary_ff <= pwdata;
            pitt_pkg::CSR_PLANE_TOL: tol_ff  <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         pitt_pkg::CSR_BARY_TOL:  prdata = bary_ff;
         pitt_pkg::CSR_PLANE_TOL: prdata = {16'b0, tol_ff};
      endcase
   end

   // Squared plane tolerance, follows the register
   always_ff @(posedge clock) begin
      tolsq_ff <= {16'b0, tol_ff} * {16'b0, tol_ff};
   end

   assign bary_op  = {1'b0, bary_ff};
   assign tolsq_op = {1'b0, tolsq_ff};

   // ------------------------------------------------------------------
   // Stage 1: e0 = C - A, e1 = B - A, w = P - A
   assign a_in[0] = req_a_x;
   assign a_in[1] = req_a_y;
   assign a_in[2] = req_a_z;
   assign b_in[0] = req_b_x;
   assign b_in[1] = req_b_y;
   assign b_in[2] = req_b_z;
   assign c_in[0] = req_c_x;
   assign c_in[1] = req_c_y;
   assign c_in[2] = req_c_z;
   assign p_in[0] = req_p_x;
   assign p_in[1] = req_p_y;
   assign p_in[2] = req_p_z;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            e0_ff[k] <= DW'(c_in[k]) - DW'(a_in[k]);
            e1_ff[k] <= DW'(b_in[k]) - DW'(a_in[k]);
            w1_ff[k] <= DW'(p_in[k]) - DW'(a_in[k]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: per-axis products for dot and cross products
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            p00_ff[k] <= e0_ff[k] * e0_ff[k];
            p01_ff[k] <= e0_ff[k] * e1_ff[k];
            p02_ff[k] <= e0_ff[k] * w1_ff[k];
            p11_ff[k] <= e1_ff[k] * e1_ff[k];
            p12_ff[k] <= e1_ff[k] * w1_ff[k];
            w2_ff[k]  <= w1_ff[k];
         end
         cra_ff[0] <= e0_ff[1] * e1_ff[2];
         crb_ff[0] <= e0_ff[2] * e1_ff[1];
         cra_ff[1] <= e0_ff[2] * e1_ff[0];
         crb_ff[1] <= e0_ff[0] * e1_ff[2];
         cra_ff[2] <= e0_ff[0] * e1_ff[1];
         crb_ff[2] <= e0_ff[1] * e1_ff[0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: dot products and normal n = e0 x e1
   always_ff @(posedge clock) begin
      if (advance) begin
         d00_ff <= DOTW'(p00_ff[0]) + DOTW'(p00_ff[1]) + DOTW'(p00_ff[2]);
         d01_ff <= DOTW'(p01_ff[0]) + DOTW'(p01_ff[1]) + DOTW'(p01_ff[2]);
         d02_ff <= DOTW'(p02_ff[0]) + DOTW'(p02_ff[1]) + DOTW'(p02_ff[2]);
         d11_ff <= DOTW'(p11_ff[0]) + DOTW'(p11_ff[1]) + DOTW'(p11_ff[2]);
         d12_ff <= DOTW'(p12_ff[0]) + DOTW'(p12_ff[1]) + DOTW'(p12_ff[2]);
         for (int k = 0; k < 3; k++) begin
            n_ff[k]  <= NW'(cra_ff[k]) - NW'(crb_ff[k]);
            w3_ff[k] <= w2_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // First multiplier bank: Gram terms and n.w components
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d00d11 (.clock(clock), .advance(advance), .a(d00_ff), .b(d11_ff), .p(m_d00d11));
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d01d01 (.clock(clock), .advance(advance), .a(d01_ff), .b(d01_ff), .p(m_d01d01));
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d11d02 (.clock(clock), .advance(advance), .a(d11_ff), .b(d02_ff), .p(m_d11d02));
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d01d12 (.clock(clock), .advance(advance), .a(d01_ff), .b(d12_ff), .p(m_d01d12));
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d00d12 (.clock(clock), .advance(advance), .a(d00_ff), .b(d12_ff), .p(m_d00d12));
   pitt_mul #(.A_WIDTH(DOTW), .B_WIDTH(DOTW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_d01d02 (.clock(clock), .advance(advance), .a(d01_ff), .b(d02_ff), .p(m_d01d02));

   genvar gk;
   generate
      for (gk = 0; gk < 3; gk++) begin : g_nw
         pitt_mul #(.A_WIDTH(NW), .B_WIDTH(DW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
            u_mul_nw (.clock(clock), .advance(advance), .a(n_ff[gk]), .b(w3_ff[gk]),
                      .p(m_nw[gk]));
      end
   endgenerate

   // ------------------------------------------------------------------
   // Stage 4: D, U, V and n.w
   always_ff @(posedge clock) begin
      if (advance) begin
         det_ff <= DETW'(m_d00d11) - DETW'(m_d01d01);
         un_ff  <= DETW'(m_d11d02) - DETW'(m_d01d12);
         vn_ff  <= DETW'(m_d00d12) - DETW'(m_d01d02);
         nw_ff  <= NWW'(m_nw[0]) + NWW'(m_nw[1]) + NWW'(m_nw[2]);
      end
   end

   // ------------------------------------------------------------------
   // Second multiplier bank: t*D, tol^2*D, (n.w)^2
   pitt_mul #(.A_WIDTH(DETW), .B_WIDTH(TOLW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_bt (.clock(clock), .advance(advance), .a(det_ff), .b(bary_op), .p(m_bt));
   pitt_mul #(.A_WIDTH(DETW), .B_WIDTH(TOLW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_td (.clock(clock), .advance(advance), .a(det_ff), .b(tolsq_op), .p(m_td));
   pitt_mul #(.A_WIDTH(NWW), .B_WIDTH(NWW), .LIMB_WIDTH(LIMB), .TREE_DEPTH(TREE))
      u_mul_nw2 (.clock(clock), .advance(advance), .a(nw_ff), .b(nw_ff), .p(m_nw2));

   // Numerators ride alongside the second bank
   always_comb begin
      dly_in.un    = un_ff;
      dly_in.vn    = vn_ff;
      dly_in.dmuv  = DMW'(det_ff) - DMW'(un_ff) - DMW'(vn_ff);
      dly_in.degen = (det_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dly_ff[0] <= dly_in;
         for (int k = 1; k < ML; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign dly_last = dly_ff[ML-1];

   // ------------------------------------------------------------------
   // Output stage: sign of each scaled inequality
   always_comb begin
      sum_u = (FW'(dly_last.un) << pitt_pkg::FRAC_BITS) + FW'(m_bt);
      sum_v = (FW'(dly_last.vn) << pitt_pkg::FRAC_BITS) + FW'(m_bt);
      sum_s = (FW'(dly_last.dmuv) << pitt_pkg::FRAC_BITS) + FW'(m_bt);
      sum_p = FW'(m_td) - FW'(m_nw2);
      inside_in = !dly_last.degen && !sum_u[FW-1] && !sum_v[FW-1]
                  && !sum_s[FW-1] && !sum_p[FW-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inside_ff <= inside_in;
         degen_ff  <= dly_last.degen;
      end
   end

   assign rsp_inside_res = inside_ff;
   assign rsp_degenerate = degen_ff;

   // ------------------------------------------------------------------
   // Checks
   a_degen_not_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> !rsp_inside_res)
      else $error("degenerate triangle reported inside");

   a_free_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input held while output is free");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

endmodule

### test/point_in_triangle_test_unit_tb.sv
`timescale 1ns / 1ps

module point_in_triangle_test_unit_tb;

   localparam int     COORD_W        = pitt_pkg::COORD_WIDTH_DEFAULT;
   localparam longint CMAX           = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint CMIN           = -(longint'(1) << (COORD_W - 1));
   localparam int     DRAIN_CYCLES   = 20;
   localparam int     HOLD_CYCLES    = 100;
   localparam int     WORDS_PER_SET  = 208;
   localparam int     NUM_SETS       = 6;
   // no accept for this long means the block is hung
   localparam int     WATCHDOG_LIMIT = 2000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [255:0]       wide_type;

   typedef struct {
      coord_type a[3];
      coord_type b[3];
      coord_type c[3];
      coord_type p[3];
   } tri_query_type;

   typedef struct packed {
      logic in_tri;
      logic degen;
   } verdict_type;

   // Predicts the verdict of each accepted word and checks results in order
   class tri_scoreboard;
      logic [31:0] bary_tol;
      logic [15:0] plane_tol;
      verdict_type expected_q[$];
      int          fails;

      function new();
         bary_tol  = pitt_pkg::BARY_TOL_RESET;
         plane_tol = pitt_pkg::PLANE_TOL_RESET;
         fails     = 0;
      endfunction

      function void set_reg(pitt_pkg::csr_reg_type sel, logic [31:0] value);
         case (sel)
            pitt_pkg::CSR_BARY_TOL: begin
               bary_tol = value;
            end
            pitt_pkg::CSR_PLANE_TOL: begin
               plane_tol = value[15:0];
            end
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Exact barycentric and plane-distance test, 256-bit signed math
      function void note_query(tri_query_type q);
         wide_type    e0[3], e1[3], w[3], nrm[3];
         wide_type    d00, d01, d02, d11, d12, det, un, vn;
         wide_type    bt, pt, nw, chk;
         verdict_type v;
         for (int k = 0; k < 3; k++) begin
            e0[k] = wide_type'(q.c[k]) - wide_type'(q.a[k]);
            e1[k] = wide_type'(q.b[k]) - wide_type'(q.a[k]);
            w[k]  = wide_type'(q.p[k]) - wide_type'(q.a[k]);
         end
         d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
         d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
         d02 = e0[0] * w[0]  + e0[1] * w[1]  + e0[2] * w[2];
         d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
         d12 = e1[0] * w[0]  + e1[1] * w[1]  + e1[2] * w[2];
         det = d00 * d11 - d01 * d01;
         if (det == 0) begin
            v.in_tri = 1'b0;
            v.degen  = 1'b1;
         end else begin
            un = d11 * d02 - d01 * d12;
            vn = d00 * d12 - d01 * d02;
            bt = 0;
            bt[31:0] = bary_tol;
            bt = bt * det;
            v.degen  = 1'b0;
            v.in_tri = 1'b1;
            // u >= -t
            chk = (un <<< pitt_pkg::FRAC_BITS) + bt;
            if (chk[255]) v.in_tri = 1'b0;
            // v >= -t
            chk = (vn <<< pitt_pkg::FRAC_BITS) + bt;
            if (chk[255]) v.in_tri = 1'b0;
            // u + v <= 1 + t
            chk = (det <<< pitt_pkg::FRAC_BITS) + bt - ((un + vn) <<< pitt_pkg::FRAC_BITS);
            if (chk[255]) v.in_tri = 1'b0;
            // squared distance to plane, scaled by |n|^2 = det
            nrm[0] = e0[1] * e1[2] - e0[2] * e1[1];
            nrm[1] = e0[2] * e1[0] - e0[0] * e1[2];
            nrm[2] = e0[0] * e1[1] - e0[1] * e1[0];
            nw = nrm[0] * w[0] + nrm[1] * w[1] + nrm[2] * w[2];
            pt = 0;
            pt[15:0] = plane_tol;
            chk = pt * pt * det - nw * nw;
            if (chk[255]) v.in_tri = 1'b0;
         end
         expected_q.insert(expected_q.size(), v);
      endfunction

      function void check_verdict(logic in_tri, logic degen);
         verdict_type v;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result inside_res=%0b degenerate=%0b, expected none",
                     $time, in_tri, degen);
            fails++;
         end else begin
            v = expected_q.pop_front();
            if (in_tri !== v.in_tri) begin
               $display("%0t: inside_res expected %0b actual %0b", $time, v.in_tri, in_tri);
               fails++;
            end
            if (degen !== v.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time, v.degen, degen);
               fails++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   coord_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   coord_type req_c_x = '0, req_c_y = '0, req_c_z = '0;
   coord_type req_p_x = '0, req_p_y = '0, req_p_z = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res;
   logic rsp_degenerate;

   logic                                psel    = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite  = 1'b0;
   logic [pitt_pkg::CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [31:0]                         pwdata  = '0;
   logic [31:0]                         prdata;
   logic                                pready;

   tri_scoreboard sb = new();

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_req      = 0;
   int holds_done    = 0;
   int quiet_cycles  = 0;

   point_in_triangle_test_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_a_x        (req_a_x),
      .req_a_y        (req_a_y),
      .req_a_z        (req_a_z),
      .req_b_x        (req_b_x),
      .req_b_y        (req_b_y),
      .req_b_z        (req_b_z),
      .req_c_x        (req_c_x),
      .req_c_y        (req_c_y),
      .req_c_z        (req_c_z),
      .req_p_x        (req_p_x),
      .req_p_y        (req_p_y),
      .req_p_z        (req_p_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .rsp_degenerate (rsp_degenerate),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: record accepted words, check accepted results
   always @(posedge clock) begin
      tri_query_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.a[0] = req_a_x; seen.a[1] = req_a_y; seen.a[2] = req_a_z;
            seen.b[0] = req_b_x; seen.b[1] = req_b_y; seen.b[2] = req_b_z;
            seen.c[0] = req_c_x; seen.c[1] = req_c_y; seen.c[2] = req_c_z;
            seen.p[0] = req_p_x; seen.p[1] = req_p_y; seen.p[2] = req_p_z;
            sb.note_query(seen);
         end
         if (rsp_valid && !rsp_stall)
            sb.check_verdict(rsp_inside_res, rsp_degenerate);
      end
   end

   // Watchdog on cycles without any accepted word, accepted result or register access
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Result side: random stall, or a long hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (holds_done < hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic longint rand_span(int bits);
      return longint'($urandom_range(0, (32'd1 << (bits + 1)) - 1)) - (longint'(1) << bits);
   endfunction

   function automatic tri_query_type make_query(longint ax, ay, az, bx, by, bz,
                                                longint cx, cy, cz, px, py, pz);
      tri_query_type q;
      q.a[0] = coord_type'(ax); q.a[1] = coord_type'(ay); q.a[2] = coord_type'(az);
      q.b[0] = coord_type'(bx); q.b[1] = coord_type'(by); q.b[2] = coord_type'(bz);
      q.c[0] = coord_type'(cx); q.c[1] = coord_type'(cy); q.c[2] = coord_type'(cz);
      q.p[0] = coord_type'(px); q.p[1] = coord_type'(py); q.p[2] = coord_type'(pz);
      return q;
   endfunction

   // Mostly real triangles with points placed around them; some collinear
   // triangles, some points on vertices and edges, some raw noise
   function automatic tri_query_type random_query();
      tri_query_type q;
      int            pick, scale, den, s, t, mult, corner;
      longint        av[3], e0v[3], e1v[3], pv[3];
      pick = $urandom_range(99);
      if (pick < 15) begin
         for (int k = 0; k < 3; k++) begin
            q.a[k] = coord_type'($urandom);
            q.b[k] = coord_type'($urandom);
            q.c[k] = coord_type'($urandom);
            q.p[k] = coord_type'($urandom);
         end
         return q;
      end
      scale = (pick % 8 == 0) ? 21 : $urandom_range(1, 18);
      for (int k = 0; k < 3; k++) begin
         av[k]  = rand_span(scale);
         e0v[k] = rand_span(scale);
         e1v[k] = rand_span(scale);
      end
      if (pick < 25) begin
         // collinear or coincident vertices
         mult = int'($urandom_range(0, 4)) - 2;
         for (int k = 0; k < 3; k++) e1v[k] = e0v[k] * mult;
      end else if ($urandom_range(1)) begin
         // flat in z: plane distance is exact
         e0v[2] = 0;
         e1v[2] = 0;
      end
      den = 1 << $urandom_range(0, 8);
      s = int'($urandom_range(0, den * 5 / 4 + 2)) - den / 8 - 1;
      t = int'($urandom_range(0, den * 5 / 4 + 2)) - den / 8 - 1;
      for (int k = 0; k < 3; k++) begin
         pv[k] = av[k] + (s * e0v[k] + t * e1v[k]) / den;
         if ($urandom_range(3) == 0) pv[k] += rand_span(3);
      end
      if (pick >= 85) begin
         corner = $urandom_range(4);
         for (int k = 0; k < 3; k++) begin
            case (corner)
               0: pv[k] = av[k];
               1: pv[k] = av[k] + e0v[k];
               2: pv[k] = av[k] + e1v[k];
               3: pv[k] = av[k] + ((e0v[k] + e1v[k]) >>> 1);
               default: pv[k] = av[k] + (e0v[k] >>> 1);
            endcase
         end
      end
      for (int k = 0; k < 3; k++) begin
         q.a[k] = coord_type'(av[k]);
         q.c[k] = coord_type'(av[k] + e0v[k]);
         q.b[k] = coord_type'(av[k] + e1v[k]);
         q.p[k] = coord_type'(pv[k]);
      end
      return q;
   endfunction

   // Offer one word at a falling edge, hold it until accepted; returns at a falling edge
   task automatic send_query(tri_query_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_a_x <= q.a[0]; req_a_y <= q.a[1]; req_a_z <= q.a[2];
      req_b_x <= q.b[0]; req_b_y <= q.b[1]; req_b_z <= q.b[2];
      req_c_x <= q.c[0]; req_c_y <= q.c[1]; req_c_z <= q.c[2];
      req_p_x <= q.p[0]; req_p_y <= q.p[1]; req_p_z <= q.p[2];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Register write followed by a readback check; returns at a falling edge
   task automatic csr_write(pitt_pkg::csr_reg_type sel, logic [31:0] value);
      logic [31:0] mask;
      mask = (sel == pitt_pkg::CSR_PLANE_TOL) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(sel, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         $display("%0t: readback of %s expected %h actual %h",
                  $time, sel.name(), value & mask, prdata & mask);
         sb.fails++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Block is idle once every result is back and the pipe has emptied
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] bt;
      logic [15:0] pt;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words, register defaults
      send_idle_pct = 31;
      rsp_idle_pct  = 78;
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 1));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 100, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, -1, 10, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 10, -1, 0));
      send_query(make_query(0, 0, 0, 100, 0, 0, 0, 100, 0, 51, 50, 0));
      send_query(make_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));
      send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                            0, 0, 0));
      send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
                            CMIN, CMIN, CMIN));
      send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
                            CMAX, CMAX, CMAX));
      send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
                            -1, -1, CMIN));
      send_query(make_query(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX,
                            0, 0, CMAX));
      send_query(make_query(CMAX, CMIN, 0, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN,
                            CMIN, CMAX, CMIN));
      send_query(make_query(0, 0, 0, 1000, 0, 1000, 0, 1000, 1000, 300, 300, 600));
      send_query(make_query(0, 0, 0, 1000, 0, 1000, 0, 1000, 1000, 300, 300, 601));
      send_query(make_query(24'h555555, 24'hAAAAAA, 24'h555555,
                            24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                            24'h555555, 24'h555555, 24'hAAAAAA,
                            24'hAAAAAA, 24'hAAAAAA, 24'h555555));

      // Random words over several register settings and idling patterns
      for (int set = 0; set < NUM_SETS; set++) begin
         req_valid <= 1'b0;
         wait_drained();
         case (set)
            0: begin
               bt = 32'd0;
               pt = 16'd0;
            end
            1: begin
               bt = 32'hFFFF_FFFF;
               pt = 16'hFFFF;
            end
            2: begin
               bt = $urandom_range(0, 32'd1 << 24);
               pt = 16'($urandom_range(0, 64));
            end
            3: begin
               bt = $urandom;
               pt = 16'($urandom);
            end
            4: begin
               bt = 32'h8000_0000;
               pt = 16'd1;
            end
            default: begin
               bt = pitt_pkg::BARY_TOL_RESET;
               pt = 16'd3;
            end
         endcase
         csr_write(pitt_pkg::CSR_BARY_TOL, bt);
         csr_write(pitt_pkg::CSR_PLANE_TOL, {16'd0, pt});
         if (set < 2) begin
            send_idle_pct = 31;
            rsp_idle_pct  = 78;
         end else if (set < 4) begin
            send_idle_pct = 78;
            rsp_idle_pct  = 31;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         // back-pressure: result side holds off while words keep coming
         if (set == 4) hold_req++;
         repeat (WORDS_PER_SET) send_query(random_query());
      end

      req_valid <= 1'b0;
      wait_drained();
      if (sb.fails == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
